// File: hw/rtl/tbag_pkg.sv
package tbag_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_BASE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_BASE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_LAYER_COUNT  = 3'd2;
	localparam logic [2:0] REG_MIP_COUNT    = 3'd3;
	localparam logic [2:0] REG_FORMAT_CLASS = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int SIZE_W     = 15;
	localparam int BLOCKS_W   = 13;
	localparam int PITCH_W    = 20;
	localparam int LP_W       = 32;
	localparam int OFFSET_W   = 43;
	localparam int COLTERM_W  = 17;

	localparam logic [SIZE_W-1:0] MAX_SIZE   = 15'd16384;
	localparam logic [11:0]       MAX_LAYERS = 12'd2048;

	typedef enum logic [1:0] {
		FMT_PIX4  = 2'd0,
		FMT_PIX8  = 2'd1,
		FMT_BLK8  = 2'd2,
		FMT_BLK16 = 2'd3
	} format_t;

	typedef struct packed {
		logic [SIZE_W-1:0] base_width;
		logic [SIZE_W-1:0] base_height;
		logic [11:0]       layer_count;
		logic [4:0]        mip_count;
		format_t           format_class;
	} cfg_t;

	// geometry of one mip level; layer pitch is mul_a * mul_b
	typedef struct packed {
		logic [SIZE_W-1:0]   w;
		logic [SIZE_W-1:0]   h;
		logic [BLOCKS_W-1:0] hb;
		logic [BLOCKS_W-1:0] vb;
		logic [PITCH_W-1:0]  brow_pitch;
		logic [PITCH_W-1:0]  mul_a;
		logic [SIZE_W-1:0]   mul_b;
	} geom_t;

	typedef enum logic [2:0] {
		ST_BUILD_PITCH,
		ST_BUILD_ACC,
		ST_IDLE,
		ST_GEOM,
		ST_MUL,
		ST_SUM
	} state_t;

endpackage

// File: hw/rtl/tbag_if.sv
interface tbag_req_if;
	logic        valid;
	logic        ready;
	logic [11:0] block_col;
	logic [11:0] block_row;
	logic [10:0] layer_index;
	logic [3:0]  mip_level;

	modport source (output valid, block_col, block_row, layer_index, mip_level, input ready);
	modport sink   (input valid, block_col, block_row, layer_index, mip_level, output ready);
endinterface

interface tbag_rsp_if;
	logic        valid;
	logic        ready;
	logic [42:0] byte_offset;
	logic [1:0]  last_col;
	logic [1:0]  last_row;
	logic        in_range;

	modport source (output valid, byte_offset, last_col, last_row, in_range, input ready);
	modport sink   (input valid, byte_offset, last_col, last_row, in_range, output ready);
endinterface

// File: hw/rtl/tbag_offset_mem.sv
module tbag_offset_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [tbag_pkg::OFFSET_W-1:0] wdata,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [tbag_pkg::OFFSET_W-1:0] rdata
);

	logic [tbag_pkg::OFFSET_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/tbag_geom.sv
module tbag_geom (
	input  tbag_pkg::cfg_t  cfg,
	input  logic [3:0]      mip,
	output tbag_pkg::geom_t geom
);

	logic [tbag_pkg::SIZE_W-1:0]  cw, ch, sw, sh, w, h;
	logic [tbag_pkg::SIZE_W-1:0]  hb_full, vb_full;
	logic [tbag_pkg::PITCH_W-1:0] line_bytes;

	// clamp to 1..16384, shift down, clamp at 1
	always_comb begin
		if (cfg.base_width == '0)
			cw = tbag_pkg::SIZE_W'(1);
		else if (cfg.base_width > tbag_pkg::MAX_SIZE)
			cw = tbag_pkg::MAX_SIZE;
		else
			cw = cfg.base_width;
		if (cfg.base_height == '0)
			ch = tbag_pkg::SIZE_W'(1);
		else if (cfg.base_height > tbag_pkg::MAX_SIZE)
			ch = tbag_pkg::MAX_SIZE;
		else
			ch = cfg.base_height;
		sw = cw >> mip;
		sh = ch >> mip;
		w  = (sw == '0) ? tbag_pkg::SIZE_W'(1) : sw;
		h  = (sh == '0) ? tbag_pkg::SIZE_W'(1) : sh;
		hb_full = (w + tbag_pkg::SIZE_W'(3)) >> 2;
		vb_full = (h + tbag_pkg::SIZE_W'(3)) >> 2;
	end

	always_comb begin
		geom.w  = w;
		geom.h  = h;
		geom.hb = hb_full[tbag_pkg::BLOCKS_W-1:0];
		geom.vb = vb_full[tbag_pkg::BLOCKS_W-1:0];
		line_bytes = '0;
		case (cfg.format_class)
			tbag_pkg::FMT_PIX4: begin
				line_bytes      = tbag_pkg::PITCH_W'(w) << 2;
				geom.brow_pitch = line_bytes << 2;
				geom.mul_a      = line_bytes;
				geom.mul_b      = h;
			end
			tbag_pkg::FMT_PIX8: begin
				line_bytes      = tbag_pkg::PITCH_W'(w) << 3;
				geom.brow_pitch = line_bytes << 2;
				geom.mul_a      = line_bytes;
				geom.mul_b      = h;
			end
			tbag_pkg::FMT_BLK8: begin
				geom.brow_pitch = tbag_pkg::PITCH_W'(geom.hb) << 3;
				geom.mul_a      = geom.brow_pitch;
				geom.mul_b      = tbag_pkg::SIZE_W'(geom.vb);
			end
			default: begin
				geom.brow_pitch = tbag_pkg::PITCH_W'(geom.hb) << 4;
				geom.mul_a      = geom.brow_pitch;
				geom.mul_b      = tbag_pkg::SIZE_W'(geom.vb);
			end
		endcase
	end

endmodule

// File: hw/rtl/texture_block_address_gen.sv
// Texture block address generator for a layered mip chain.
// Requests arrive on req (valid/ready): block column, block row, layer and mip.
// Each request yields one response on rsp (valid/ready): byte offset of the
// 4x4 block, last valid column and row inside it, and an in-range flag. An
// out-of-range request returns all-zero fields with in_range low.
// Configuration is written through cfg_we / cfg_index / cfg_wdata.
// The start offset of every mip level lives in a small table memory. After
// reset and after every configuration write the table is rebuilt entry by
// entry through BUILD_PITCH and BUILD_ACC; req.ready stays low meanwhile.
// The table is read when a request is accepted; then the level geometry and
// the pitch products are registered in turn, and the final sum is loaded into
// the response register. One request is in flight at a time and ready
// returns the cycle after the response load.
// The response register decouples the output: a new request is accepted while
// a finished response still waits. If rsp stalls with a response held, the
// next request finishes its sum and waits there until the register frees.
// Reset: registers return to width 1, height 1, one layer, one mip, 4-byte
// pixels, and the offset table rebuild starts.
module texture_block_address_gen #(
	parameter int MAX_MIPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tbag_req_if.sink                          req,
	tbag_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [tbag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = (MAX_MIPS > 1) ? $clog2(MAX_MIPS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_MIPS - 1);
	localparam logic [4:0] MIPS_CAP = 5'(MAX_MIPS);

	tbag_pkg::cfg_t   cfg_q;
	tbag_pkg::state_t state_q, state_d;
	tbag_pkg::geom_t  geom;

	logic [AW-1:0]                  build_idx_q;
	logic [tbag_pkg::OFFSET_W-1:0] acc_q;
	logic [tbag_pkg::LP_W-1:0]     lp_q;
	logic [34:0]                    lp_full;
	logic [43:0]                    layer_prod;

	logic [11:0] col_q, row_q;
	logic [10:0] layer_q;
	logic [3:0]  mip_q;
	logic [3:0]  geom_mip;

	logic [4:0]  mips;
	logic [11:0] layers;

	logic                           ok_q;
	logic [1:0]                     last_col_q, last_row_q;
	logic [tbag_pkg::PITCH_W-1:0]  brp_q;
	logic [tbag_pkg::COLTERM_W-1:0] colterm_q;
	logic [tbag_pkg::OFFSET_W-1:0] prod_a_q;
	logic [31:0]                    prod_b_q;
	logic [tbag_pkg::OFFSET_W-1:0] mem_rdata;
	logic [tbag_pkg::OFFSET_W-1:0] sum;

	logic req_fire, rsp_load, mem_we;
	logic [tbag_pkg::SIZE_W-1:0] rem_w, rem_h;
	logic ok_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_width   <= tbag_pkg::SIZE_W'(1);
			cfg_q.base_height  <= tbag_pkg::SIZE_W'(1);
			cfg_q.layer_count  <= 12'd1;
			cfg_q.mip_count    <= 5'd1;
			cfg_q.format_class <= tbag_pkg::FMT_PIX4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbag_pkg::REG_BASE_WIDTH:   cfg_q.base_width  <= cfg_wdata;
				tbag_pkg::REG_BASE_HEIGHT:  cfg_q.base_height <= cfg_wdata;
				tbag_pkg::REG_LAYER_COUNT:  cfg_q.layer_count <= cfg_wdata[11:0];
				tbag_pkg::REG_MIP_COUNT:    cfg_q.mip_count   <= cfg_wdata[4:0];
				tbag_pkg::REG_FORMAT_CLASS:
					cfg_q.format_class <= tbag_pkg::format_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	assign mips   = (cfg_q.mip_count > MIPS_CAP) ? MIPS_CAP : cfg_q.mip_count;
	assign layers = (cfg_q.layer_count > tbag_pkg::MAX_LAYERS) ? tbag_pkg::MAX_LAYERS
	                                                             : cfg_q.layer_count;

	// one geometry unit, shared by the table rebuild and the request path
	assign geom_mip = (state_q == tbag_pkg::ST_BUILD_PITCH) ? 4'(build_idx_q) : mip_q;

	tbag_geom u_geom (
		.cfg  (cfg_q),
		.mip  (geom_mip),
		.geom (geom)
	);

	assign lp_full    = 35'(geom.mul_a) * 35'(geom.mul_b);
	assign layer_prod = 44'(lp_q) * 44'(layers);

	// table of mip start offsets
	assign mem_we = (state_q == tbag_pkg::ST_BUILD_ACC);

	tbag_offset_mem #(
		.DEPTH (MAX_MIPS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (build_idx_q),
		.wdata (acc_q),
		.re    (req_fire),
		.raddr (req.mip_level[AW-1:0]),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == tbag_pkg::ST_IDLE) && !cfg_we;
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == tbag_pkg::ST_SUM) && (!rsp.valid || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbag_pkg::ST_BUILD_PITCH: state_d = tbag_pkg::ST_BUILD_ACC;
			tbag_pkg::ST_BUILD_ACC:
				state_d = (build_idx_q == LAST_IDX) ? tbag_pkg::ST_IDLE
				                                    : tbag_pkg::ST_BUILD_PITCH;
			tbag_pkg::ST_IDLE:  if (req_fire) state_d = tbag_pkg::ST_GEOM;
			tbag_pkg::ST_GEOM:  state_d = tbag_pkg::ST_MUL;
			tbag_pkg::ST_MUL:   state_d = tbag_pkg::ST_SUM;
			tbag_pkg::ST_SUM:   if (rsp_load) state_d = tbag_pkg::ST_IDLE;
			default:            state_d = tbag_pkg::ST_IDLE;
		endcase
		// any register write invalidates the table
		if (cfg_we) state_d = tbag_pkg::ST_BUILD_PITCH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbag_pkg::ST_BUILD_PITCH;
		end else begin
			state_q <= state_d;
		end
	end

	// rebuild counter and running offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			build_idx_q <= '0;
			acc_q       <= '0;
		end else if (cfg_we) begin
			build_idx_q <= '0;
			acc_q       <= '0;
		end else if (state_q == tbag_pkg::ST_BUILD_ACC) begin
			build_idx_q <= build_idx_q + AW'(1);
			acc_q       <= acc_q + layer_prod[tbag_pkg::OFFSET_W-1:0];
		end
	end

	// edge remainders, valid only when the block lies inside the level
	always_comb begin
		rem_w = geom.w - {1'b0, col_q, 2'b00};
		rem_h = geom.h - {1'b0, row_q, 2'b00};
		ok_d  = ({1'b0, mip_q} < mips) && ({1'b0, layer_q} < layers)
		        && ({1'b0, col_q} < geom.hb) && ({1'b0, row_q} < geom.vb);
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (req_fire) begin
			col_q   <= req.block_col;
			row_q   <= req.block_row;
			layer_q <= req.layer_index;
			mip_q   <= req.mip_level;
		end
		if (state_q == tbag_pkg::ST_BUILD_PITCH || state_q == tbag_pkg::ST_GEOM) begin
			lp_q <= lp_full[tbag_pkg::LP_W-1:0];
		end
		if (state_q == tbag_pkg::ST_GEOM) begin
			ok_q       <= ok_d;
			brp_q      <= geom.brow_pitch;
			last_col_q <= (rem_w >= tbag_pkg::SIZE_W'(4)) ? 2'd3 : 2'(rem_w - 1'b1);
			last_row_q <= (rem_h >= tbag_pkg::SIZE_W'(4)) ? 2'd3 : 2'(rem_h - 1'b1);
			case (cfg_q.format_class)
				tbag_pkg::FMT_PIX4:  colterm_q <= tbag_pkg::COLTERM_W'(col_q) << 4;
				tbag_pkg::FMT_PIX8:  colterm_q <= tbag_pkg::COLTERM_W'(col_q) << 5;
				tbag_pkg::FMT_BLK8:  colterm_q <= tbag_pkg::COLTERM_W'(col_q) << 3;
				default:             colterm_q <= tbag_pkg::COLTERM_W'(col_q) << 4;
			endcase
		end
		if (state_q == tbag_pkg::ST_MUL) begin
			prod_a_q <= tbag_pkg::OFFSET_W'(lp_q) * tbag_pkg::OFFSET_W'(layer_q);
			prod_b_q <= 32'(brp_q) * 32'(row_q);
		end
	end

	assign sum = mem_rdata + prod_a_q + tbag_pkg::OFFSET_W'(prod_b_q)
	             + tbag_pkg::OFFSET_W'(colterm_q);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (rsp_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.byte_offset <= ok_q ? sum : '0;
			rsp.last_col    <= ok_q ? last_col_q : 2'd0;
			rsp.last_row    <= ok_q ? last_row_q : 2'd0;
			rsp.in_range    <= ok_q;
		end
	end

endmodule
